/* src/agam_pkg.sv */
// ----------------------------------------------------------------------------
// agam_pkg
// Shared types and constants of the adaptive gain audio mixer: controller
// states, the command and status groups between controller and datapath,
// and the fixed-point constants of the gain loop.
// ----------------------------------------------------------------------------
package agam_pkg;

    localparam int SAMPLE_FIELDS = 4;
    localparam int DIV_STEPS     = 16;
    localparam int RECOVER_SHIFT = 5;

    localparam logic [16:0] GAIN_ONE = 17'd65536;
    localparam logic [17:0] POS_LIMIT = 18'd32767;
    localparam logic [17:0] NEG_LIMIT = 18'd32768;
    localparam logic signed [15:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] OUT_MIN = 16'sh8000;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic check;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clip;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

/* src/agam_ctrl.sv */
// ----------------------------------------------------------------------------
// agam_ctrl
// Sequencer of the mixer: takes one transaction, steps the datapath through
// scaling, saturation check, optional gain division and result hand-off.
// ----------------------------------------------------------------------------
module agam_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  agam_pkg::t_sts i_sts,
    output agam_pkg::t_cmd o_cmd
);

    agam_pkg::t_state r_state;
    agam_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= agam_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            agam_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = agam_pkg::ST_MUL;
                end
            end
            agam_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = agam_pkg::ST_CHECK;
            end
            agam_pkg::ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.clip ? agam_pkg::ST_DIV : agam_pkg::ST_DONE;
            end
            agam_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = agam_pkg::ST_DONE;
                end
            end
            agam_pkg::ST_DONE: begin
                // Hold until the output register can take the result.
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = agam_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = agam_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* src/agam_dp.sv */
// ----------------------------------------------------------------------------
// agam_dp
// Datapath of the mixer: track summation, gain multiply, saturation,
// restoring divider for the new gain, gain recovery and output register.
// ----------------------------------------------------------------------------
module agam_dp #(
    parameter int TRACKS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [15:0] i_sample_0,
    input  logic signed [15:0] i_sample_1,
    input  logic signed [15:0] i_sample_2,
    input  logic signed [15:0] i_sample_3,
    input  logic [2:0]         i_track_count,
    input  logic               i_block_start,
    input  agam_pkg::t_cmd     i_cmd,
    output agam_pkg::t_sts     o_sts,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_mixed_sample,
    output logic               o_clipped
);

    localparam int TrackLimit =
        (TRACKS < agam_pkg::SAMPLE_FIELDS) ? TRACKS : agam_pkg::SAMPLE_FIELDS;
    localparam logic [2:0] LimitBits = 3'(TrackLimit);

    logic signed [15:0] samples [agam_pkg::SAMPLE_FIELDS];
    logic [2:0]         count_eff;
    logic signed [18:0] sum;
    logic [17:0]        sum_mag;
    logic [34:0]        product;
    logic               clip_pos;
    logic               clip_neg;
    logic [18:0]        neg_res;
    logic [18:0]        rem_shift;
    logic [18:0]        rem_diff;
    logic [16:0]        gain_pre;
    logic [16:0]        gain_step;

    logic [16:0]        r_gain;
    logic               r_neg;
    logic [17:0]        r_mag;
    logic [17:0]        r_pm;
    logic               r_clip;
    logic signed [15:0] r_res;
    logic [17:0]        r_rem;
    logic [17:0]        r_div;
    logic [15:0]        r_quo;
    logic [3:0]         r_cnt;
    logic               r_out_valid;
    logic signed [15:0] r_out_sample;
    logic               r_out_clip;

    assign samples[0] = i_sample_0;
    assign samples[1] = i_sample_1;
    assign samples[2] = i_sample_2;
    assign samples[3] = i_sample_3;

    always_comb begin
        count_eff = (i_track_count > LimitBits) ? LimitBits : i_track_count;
        sum       = '0;
        for (int i = 0; i < agam_pkg::SAMPLE_FIELDS; i++) begin
            if (3'(i) < count_eff) begin
                sum = sum + 19'(samples[i]);
            end
        end
        sum_mag = sum[18] ? 18'(-sum) : 18'(sum);
    end

    // A gain reset by block start must take effect before this item is scaled,
    // so the multiply reads the gain after the load cycle.
    assign product  = 35'(r_mag) * 35'(r_gain);
    assign clip_pos = !r_neg && (r_pm > agam_pkg::POS_LIMIT);
    assign clip_neg = r_neg && (r_pm > agam_pkg::NEG_LIMIT);
    assign neg_res  = 19'(0) - {1'b0, r_pm};

    assign rem_shift = {r_rem, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, r_div};

    assign gain_pre  = r_clip ? {1'b0, r_quo} : r_gain;
    assign gain_step = (agam_pkg::GAIN_ONE - gain_pre) >> agam_pkg::RECOVER_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= agam_pkg::GAIN_ONE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && i_block_start) begin
                r_gain <= agam_pkg::GAIN_ONE;
            end else if (i_cmd.finish && (gain_pre < agam_pkg::GAIN_ONE)) begin
                r_gain <= gain_pre + gain_step;
            end else if (i_cmd.finish) begin
                r_gain <= gain_pre;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= sum[18];
            r_mag <= sum_mag;
        end
        if (i_cmd.mul) begin
            r_pm <= product[33:16];
        end
        if (i_cmd.check) begin
            r_clip <= clip_pos || clip_neg;
            if (clip_pos) begin
                r_res <= agam_pkg::OUT_MAX;
            end else if (clip_neg) begin
                r_res <= agam_pkg::OUT_MIN;
            end else if (r_neg) begin
                r_res <= neg_res[15:0];
            end else begin
                r_res <= r_pm[15:0];
            end
            // The limit times 1.0 has its upper eighteen quotient bits at zero,
            // so the divider starts with the limit as partial remainder.
            r_rem <= r_neg ? agam_pkg::NEG_LIMIT : agam_pkg::POS_LIMIT;
            r_div <= r_pm;
            r_quo <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 4'd1;
            if (rem_shift >= {1'b0, r_div}) begin
                r_rem <= rem_diff[17:0];
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= rem_shift[17:0];
                r_quo <= {r_quo[14:0], 1'b0};
            end
        end
        if (i_cmd.finish) begin
            r_out_sample <= r_res;
            r_out_clip   <= r_clip;
        end
    end

    assign o_sts.clip     = clip_pos || clip_neg;
    assign o_sts.div_last = (r_cnt == 4'(agam_pkg::DIV_STEPS - 1));
    assign o_sts.out_free = !r_out_valid || i_ready;

    assign o_valid        = r_out_valid;
    assign o_mixed_sample = r_out_sample;
    assign o_clipped      = r_out_clip;

endmodule

/* src/adaptive_gain_audio_mixer.sv */
// ----------------------------------------------------------------------------
// adaptive_gain_audio_mixer
// Mixes up to four 16-bit tracks with a running Q1.16 gain that drops on
// saturation and recovers toward unity on each following sample.
// ----------------------------------------------------------------------------
// An item passes from acceptance through the multiply, check and done states
// to a result in the output register when the scaled sum stays in range, and
// also through the divide state when it saturates: the new gain then comes
// from a restoring divider that resolves one quotient bit per cycle over 16
// steps. The done state holds until the output register is free. One item is
// in work at a time; the next one is accepted as soon as the previous result
// sits in the output register, even while it still waits to be taken.
module adaptive_gain_audio_mixer #(
    parameter int TRACKS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_sample_0,
    input  logic signed [15:0] i_sample_1,
    input  logic signed [15:0] i_sample_2,
    input  logic signed [15:0] i_sample_3,
    input  logic [2:0]         i_track_count,
    input  logic               i_block_start,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_mixed_sample,
    output logic               o_clipped
);

    agam_pkg::t_cmd cmd;
    agam_pkg::t_sts sts;

    agam_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    agam_dp #(
        .TRACKS (TRACKS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_0     (i_sample_0),
        .i_sample_1     (i_sample_1),
        .i_sample_2     (i_sample_2),
        .i_sample_3     (i_sample_3),
        .i_track_count  (i_track_count),
        .i_block_start  (i_block_start),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_mixed_sample (o_mixed_sample),
        .o_clipped      (o_clipped)
    );

`ifndef SYNTHESIS
    // A clipped result always carries one of the two saturation values.
    a_clip_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |->
            (o_mixed_sample == agam_pkg::OUT_MAX || o_mixed_sample == agam_pkg::OUT_MIN))
        else $error("clipped result is not a saturation value");

    // After a transaction is taken, no second one is taken in the next cycle.
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> !o_ready)
        else $error("input accepted while an item is in work");

    // A result is only written when the output register is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> (!o_valid || i_ready))
        else $error("result written over a pending output");
`endif

endmodule
